FILE: src/frx_pkg.sv
// Shared types, codes and defaults for the firmware image receiver.
// No dependencies; every other file refers to it by scoped names.

package frx_pkg;

  // Default geometry of the staging flash region (pages and sectors are powers of two)
  localparam int unsigned DEF_PAGE_BYTES   = 256;
  localparam int unsigned DEF_SECTOR_BYTES = 4096;
  localparam int unsigned DEF_STAGE_BYTES  = 458752;
  localparam int unsigned DEF_STAGE_BASE   = 1572864;

  // Reflected CRC-32 polynomial
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Field widths
  localparam int unsigned SIZE_W = 19;
  localparam int unsigned CRC_W  = 32;
  localparam int unsigned ADDR_W = 21;
  localparam int unsigned LEN_W  = 8;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CODE_W = 3;

  // Configuration register indexes
  localparam logic CFG_TOTAL_SIZE   = 1'b0;
  localparam logic CFG_EXPECTED_CRC = 1'b1;

  // Reset values of the configuration registers
  localparam logic [SIZE_W-1:0] TOTAL_SIZE_RST   = 19'd1;
  localparam logic [CRC_W-1:0]  EXPECTED_CRC_RST = 32'd0;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_HEADER = 2'd1,
    OP_DATA   = 2'd2,
    OP_COMMIT = 2'd3
  } op_t;

  // Sticky error codes as reported
  localparam logic [CODE_W-1:0] ERR_NONE  = 3'd0;
  localparam logic [CODE_W-1:0] ERR_BUSY  = 3'd1;
  localparam logic [CODE_W-1:0] ERR_SIZE  = 3'd2;
  localparam logic [CODE_W-1:0] ERR_FRAME = 3'd3;
  localparam logic [CODE_W-1:0] ERR_CRC   = 3'd4;

  // Reported phase codes
  localparam logic [CODE_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [CODE_W-1:0] ST_RECV   = 3'd1;
  localparam logic [CODE_W-1:0] ST_READY  = 3'd2;
  localparam logic [CODE_W-1:0] ST_FAILED = 3'd3;
  localparam logic [CODE_W-1:0] ST_COMMIT = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_RECV   = 5'b00010,
    PH_READY  = 5'b00100,
    PH_FAILED = 5'b01000,
    PH_COMMIT = 5'b10000
  } phase_t;

  typedef struct packed {
    op_t               op;
    logic [SIZE_W-1:0] chunk_offset;
    logic [LEN_W-1:0]  chunk_length;
    logic [BYTE_W-1:0] data_byte;
    logic              capture_busy;
  } item_t;

  typedef struct packed {
    logic              accepted;
    logic [CODE_W-1:0] error_code;
    logic [CODE_W-1:0] update_state;
    logic [SIZE_W-1:0] bytes_stored;
    logic [CRC_W-1:0]  actual_crc;
    logic              erase_request;
    logic [SIZE_W-1:0] erase_length;
    logic              write_valid;
    logic [ADDR_W-1:0] write_address;
    logic [BYTE_W-1:0] write_data;
    logic              page_flush;
    logic              commit_go;
  } result_t;

  function automatic logic [CODE_W-1:0] phase_code(input phase_t ph);
    logic [CODE_W-1:0] code;
    case (ph)
      PH_IDLE:   code = ST_IDLE;
      PH_RECV:   code = ST_RECV;
      PH_READY:  code = ST_READY;
      PH_FAILED: code = ST_FAILED;
      PH_COMMIT: code = ST_COMMIT;
      default:   code = ST_IDLE;
    endcase
    return code;
  endfunction

endpackage

FILE: src/firmware_image_receiver_unit.sv
// Top level of the firmware image receiver: configuration registers,
// input and result registers, handshakes. Depends on frx_pkg and frx_ctrl.
//
//   channel  | ports                                   | direction | handshake
//   ---------+-----------------------------------------+-----------+------------------
//   in_      | op, chunk_offset, chunk_length,         | sink      | in_valid/in_ready
//            | data_byte, capture_busy                 |           |
//   out_     | accepted ... commit_go (12 fields)      | source    | out_valid/out_ready
//   cfg_     | cfg_we, cfg_index, cfg_wdata            | sink      | write on cfg_we
//
// One transaction per cycle sustained while out_ready is held high. A
// transaction waits in the input register, then the decision logic
// (byte-wide CRC, count compare, phase update) loads the result register
// once that register is free or being taken; the result then shows on
// out_ and can be taken with out_ready.
// Synchronous active-low reset clears phase, counters, error and valid flags
// and presets the CRC to all ones; total_size resets to 1 and expected_crc to 0.
// A stalled result holds the result register; the input register then holds
// its transaction and in_ready drops until the result is taken.

module firmware_image_receiver_unit #(
  parameter int unsigned PAGE_BYTES   = frx_pkg::DEF_PAGE_BYTES,
  parameter int unsigned SECTOR_BYTES = frx_pkg::DEF_SECTOR_BYTES,
  parameter int unsigned STAGE_BYTES  = frx_pkg::DEF_STAGE_BYTES,
  parameter int unsigned STAGE_BASE   = frx_pkg::DEF_STAGE_BASE
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [frx_pkg::CRC_W-1:0]    cfg_wdata,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_op,
  input  logic [frx_pkg::SIZE_W-1:0]   in_chunk_offset,
  input  logic [frx_pkg::LEN_W-1:0]    in_chunk_length,
  input  logic [frx_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                         in_capture_busy,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_accepted,
  output logic [frx_pkg::CODE_W-1:0]   out_error_code,
  output logic [frx_pkg::CODE_W-1:0]   out_update_state,
  output logic [frx_pkg::SIZE_W-1:0]   out_bytes_stored,
  output logic [frx_pkg::CRC_W-1:0]    out_actual_crc,
  output logic                         out_erase_request,
  output logic [frx_pkg::SIZE_W-1:0]   out_erase_length,
  output logic                         out_write_valid,
  output logic [frx_pkg::ADDR_W-1:0]   out_write_address,
  output logic [frx_pkg::BYTE_W-1:0]   out_write_data,
  output logic                         out_page_flush,
  output logic                         out_commit_go
);

  logic [frx_pkg::SIZE_W-1:0] total_size_r;
  logic [frx_pkg::CRC_W-1:0]  expected_crc_r;

  logic              in_vld_r;
  frx_pkg::item_t    item_r;
  logic              out_vld_r;
  frx_pkg::result_t  res_r;
  frx_pkg::result_t  res_nxt;

  logic in_fire;
  logic step_en;

  // Advance the input register whenever the result register is free or draining
  assign step_en  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || step_en;
  assign in_fire  = in_valid && in_ready;

  // Configuration writes: take the low bits of the data for the size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_size_r   <= frx_pkg::TOTAL_SIZE_RST;
      expected_crc_r <= frx_pkg::EXPECTED_CRC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        frx_pkg::CFG_TOTAL_SIZE:   total_size_r   <= cfg_wdata[frx_pkg::SIZE_W-1:0];
        frx_pkg::CFG_EXPECTED_CRC: expected_crc_r <= cfg_wdata;
        default:                   total_size_r   <= total_size_r;
      endcase
    end
  end

  // Input register: hold a transaction until the decision stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_fire) begin
      in_vld_r <= 1'b1;
    end else if (step_en) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.op           <= frx_pkg::op_t'(in_op);
      item_r.chunk_offset <= in_chunk_offset;
      item_r.chunk_length <= in_chunk_length;
      item_r.data_byte    <= in_data_byte;
      item_r.capture_busy <= in_capture_busy;
    end
  end

  frx_ctrl #(
    .PAGE_BYTES   (PAGE_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES),
    .STAGE_BYTES  (STAGE_BYTES),
    .STAGE_BASE   (STAGE_BASE)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_en),
    .item         (item_r),
    .total_size   (total_size_r),
    .expected_crc (expected_crc_r),
    .result       (res_nxt)
  );

  // Result register: load on each step, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step_en) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_accepted      = res_r.accepted;
  assign out_error_code    = res_r.error_code;
  assign out_update_state  = res_r.update_state;
  assign out_bytes_stored  = res_r.bytes_stored;
  assign out_actual_crc    = res_r.actual_crc;
  assign out_erase_request = res_r.erase_request;
  assign out_erase_length  = res_r.erase_length;
  assign out_write_valid   = res_r.write_valid;
  assign out_write_address = res_r.write_address;
  assign out_write_data    = res_r.write_data;
  assign out_page_flush    = res_r.page_flush;
  assign out_commit_go     = res_r.commit_go;

endmodule

FILE: src/frx_crc.sv
// Byte-wide update of a reflected CRC-32 register (eight shift steps).
// Depends on frx_pkg for the polynomial and widths.

module frx_crc (
  input  logic [frx_pkg::CRC_W-1:0]  crc_in,
  input  logic [frx_pkg::BYTE_W-1:0] data,
  output logic [frx_pkg::CRC_W-1:0]  crc_out
);

  always_comb begin
    logic [frx_pkg::CRC_W-1:0] c;
    c = crc_in ^ {{(frx_pkg::CRC_W-frx_pkg::BYTE_W){1'b0}}, data};
    for (int i = 0; i < frx_pkg::BYTE_W; i++) begin
      c = c[0] ? ((c >> 1) ^ frx_pkg::CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

FILE: src/frx_ctrl.sv
// Receiver state (phase, byte count, CRC, sticky error, bytes left in chunk) and
// the per-transaction decision logic. Depends on frx_pkg and frx_crc.

module frx_ctrl #(
  parameter int unsigned PAGE_BYTES   = frx_pkg::DEF_PAGE_BYTES,
  parameter int unsigned SECTOR_BYTES = frx_pkg::DEF_SECTOR_BYTES,
  parameter int unsigned STAGE_BYTES  = frx_pkg::DEF_STAGE_BYTES,
  parameter int unsigned STAGE_BASE   = frx_pkg::DEF_STAGE_BASE
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step_en,
  input  frx_pkg::item_t                   item,
  input  logic [frx_pkg::SIZE_W-1:0]       total_size,
  input  logic [frx_pkg::CRC_W-1:0]        expected_crc,
  output frx_pkg::result_t                 result
);

  localparam int unsigned WW = frx_pkg::ADDR_W;
  localparam logic [WW-1:0]              SEC_MASK   = WW'(SECTOR_BYTES - 1);
  localparam logic [WW-1:0]              STAGE_LIM  = WW'(STAGE_BYTES);
  localparam logic [WW-1:0]              BASE_ADDR  = WW'(STAGE_BASE);
  localparam logic [frx_pkg::SIZE_W-1:0] PAGE_MASK  = frx_pkg::SIZE_W'(PAGE_BYTES - 1);

  frx_pkg::phase_t                  phase_r, phase_nxt;
  logic [frx_pkg::SIZE_W-1:0]       count_r, count_nxt;
  logic [frx_pkg::CRC_W-1:0]        crc_r, crc_nxt;
  logic [frx_pkg::CODE_W-1:0]       err_r, err_nxt;
  logic [frx_pkg::LEN_W-1:0]        left_r, left_nxt;

  logic [frx_pkg::CRC_W-1:0]        crc_upd;
  logic [frx_pkg::SIZE_W-1:0]       count_inc;
  logic [WW-1:0]                    size_ext;
  logic [WW-1:0]                    chunk_end;
  logic [WW-1:0]                    erase_round;
  logic                             acc, erq, wv, pf, go;

  frx_crc u_crc (
    .crc_in  (crc_r),
    .data    (item.data_byte),
    .crc_out (crc_upd)
  );

  assign count_inc   = count_r + frx_pkg::SIZE_W'(1);
  assign size_ext    = WW'(total_size);
  assign chunk_end   = WW'(item.chunk_offset) + WW'(item.chunk_length);
  assign erase_round = (size_ext + SEC_MASK) & ~SEC_MASK;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    crc_nxt   = crc_r;
    err_nxt   = err_r;
    left_nxt  = left_r;
    acc = 1'b0;
    erq = 1'b0;
    wv  = 1'b0;
    pf  = 1'b0;
    go  = 1'b0;
    case (item.op)
      frx_pkg::OP_BEGIN: begin
        if (item.capture_busy) begin
          err_nxt = frx_pkg::ERR_BUSY;
        end else if (total_size == '0 || size_ext > STAGE_LIM) begin
          err_nxt = frx_pkg::ERR_SIZE;
        end else begin
          acc       = 1'b1;
          erq       = 1'b1;
          phase_nxt = frx_pkg::PH_RECV;
          count_nxt = '0;
          crc_nxt   = '1;
          err_nxt   = frx_pkg::ERR_NONE;
          left_nxt  = '0;
        end
      end
      frx_pkg::OP_HEADER: begin
        if (phase_r != frx_pkg::PH_RECV || item.chunk_length == '0 || left_r != '0 ||
            item.chunk_offset != count_r || chunk_end > size_ext) begin
          err_nxt = frx_pkg::ERR_FRAME;
        end else begin
          left_nxt = item.chunk_length;
          acc      = 1'b1;
        end
      end
      frx_pkg::OP_DATA: begin
        if (phase_r != frx_pkg::PH_RECV || left_r == '0 || count_r >= total_size) begin
          err_nxt = frx_pkg::ERR_FRAME;
        end else begin
          wv        = 1'b1;
          acc       = 1'b1;
          crc_nxt   = crc_upd;
          count_nxt = count_inc;
          left_nxt  = left_r - frx_pkg::LEN_W'(1);
          pf = ((count_inc & PAGE_MASK) == '0) || (count_inc == total_size);
          if (count_inc == total_size) begin
            if (~crc_upd == expected_crc) begin
              phase_nxt = frx_pkg::PH_READY;
            end else begin
              phase_nxt = frx_pkg::PH_FAILED;
              err_nxt   = frx_pkg::ERR_CRC;
              acc       = 1'b0;
            end
          end
        end
      end
      frx_pkg::OP_COMMIT: begin
        if (phase_r != frx_pkg::PH_READY || count_r != total_size) begin
          err_nxt = frx_pkg::ERR_FRAME;
        end else begin
          phase_nxt = frx_pkg::PH_COMMIT;
          go        = 1'b1;
          acc       = 1'b1;
        end
      end
      default: begin
        err_nxt = err_r;
      end
    endcase
  end

  always_comb begin
    result.accepted      = acc;
    result.error_code    = err_nxt;
    result.update_state  = frx_pkg::phase_code(phase_nxt);
    result.bytes_stored  = count_nxt;
    result.actual_crc    = ~crc_nxt;
    result.erase_request = erq;
    result.erase_length  = erq ? erase_round[frx_pkg::SIZE_W-1:0] : '0;
    result.write_valid   = wv;
    result.write_address = wv ? (BASE_ADDR + WW'(count_r)) : '0;
    result.write_data    = wv ? item.data_byte : '0;
    result.page_flush    = pf;
    result.commit_go     = go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= frx_pkg::PH_IDLE;
      count_r <= '0;
      crc_r   <= '1;
      err_r   <= frx_pkg::ERR_NONE;
      left_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      err_r   <= err_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule
